@@ design/btk_pkg.sv @@
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and constants for the dual source button tracker.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int NUM_BUTTONS_DEF = 32;
    localparam int BUTTON_IDX_W    = 5;
    localparam int KEY_W           = 8;
    localparam int SLOT_W          = 9;
    localparam int FRAC_W          = 3;

    localparam logic [SLOT_W-1:0] SLOT_EMPTY  = 9'h000;
    localparam logic [SLOT_W-1:0] SLOT_MANUAL = 9'h1FF;

    localparam logic [FRAC_W-1:0] FRAC_NONE    = 3'd0;
    localparam logic [FRAC_W-1:0] FRAC_QUARTER = 3'd1;
    localparam logic [FRAC_W-1:0] FRAC_HALF    = 3'd2;
    localparam logic [FRAC_W-1:0] FRAC_3QUART  = 3'd3;
    localparam logic [FRAC_W-1:0] FRAC_FULL    = 3'd4;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SAMPLE  = 2'd2,
        OP_LATCH   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [BUTTON_IDX_W-1:0] button_index;
        logic                    key_given;
        logic [KEY_W-1:0]        key_code;
    } cmd_t;

    typedef struct packed {
        logic [FRAC_W-1:0] held_fraction;
        logic              is_held;
        logic              action_active;
        logic              too_many_keys;
    } rsp_t;

    typedef struct packed {
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] second_slot;
        logic              rel_edge;
        logic              press_edge;
        logic              held;
    } entry_t;

endpackage

@@ design/btk_table.sv @@
// ----------------------------------------------------------------------------
// btk_table
// Per-button slot and flag storage, one write port and one read port.
// ----------------------------------------------------------------------------
module btk_table
    import btk_pkg::*;
#(
    parameter int DEPTH = NUM_BUTTONS_DEF,
    parameter int IDX_W = BUTTON_IDX_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data
);

    entry_t entry_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

@@ design/btk_update.sv @@
// ----------------------------------------------------------------------------
// btk_update
// Next entry value and response for one command applied to one button.
// ----------------------------------------------------------------------------
module btk_update
    import btk_pkg::*;
(
    input  cmd_t   cmd,
    input  entry_t cur,
    output entry_t nxt,
    output rsp_t   rsp
);

    logic [SLOT_W-1:0] key;
    logic              repeat_hit;

    assign key        = cmd.key_given ? {1'b0, cmd.key_code} : SLOT_MANUAL;
    assign repeat_hit = (key == cur.first_slot) || (key == cur.second_slot);

    always_comb
    begin
        nxt = cur;
        rsp = '0;
        case (cmd.op)
            OP_PRESS:
            begin
                if (!repeat_hit)
                begin
                    if (cur.first_slot == SLOT_EMPTY)
                    begin
                        nxt.first_slot = key;
                    end
                    else if (cur.second_slot == SLOT_EMPTY)
                    begin
                        nxt.second_slot = key;
                    end
                    else
                    begin
                        rsp.too_many_keys = 1'b1;
                    end
                    if (!rsp.too_many_keys && !cur.held)
                    begin
                        nxt.held       = 1'b1;
                        nxt.press_edge = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (!cmd.key_given)
                begin
                    nxt = '0;
                    nxt.rel_edge = 1'b1;
                end
                else
                begin
                    if (cur.first_slot == key)
                    begin
                        nxt.first_slot = SLOT_EMPTY;
                    end
                    else if (cur.second_slot == key)
                    begin
                        nxt.second_slot = SLOT_EMPTY;
                    end
                    if ((nxt.first_slot == SLOT_EMPTY) && (nxt.second_slot == SLOT_EMPTY)
                        && cur.held)
                    begin
                        nxt.held     = 1'b0;
                        nxt.rel_edge = 1'b1;
                    end
                end
            end
            OP_SAMPLE:
            begin
                case ({cur.press_edge, cur.rel_edge})
                    2'b10:   rsp.held_fraction = cur.held ? FRAC_HALF : FRAC_NONE;
                    2'b01:   rsp.held_fraction = FRAC_NONE;
                    2'b00:   rsp.held_fraction = cur.held ? FRAC_FULL : FRAC_NONE;
                    default: rsp.held_fraction = cur.held ? FRAC_3QUART : FRAC_QUARTER;
                endcase
                nxt.press_edge = 1'b0;
                nxt.rel_edge   = 1'b0;
            end
            default:
            begin
                rsp.action_active = cur.held || cur.press_edge;
                nxt.press_edge    = 1'b0;
            end
        endcase
        rsp.is_held = nxt.held;
    end

endmodule

@@ design/dual_source_button_tracker.sv @@
// ----------------------------------------------------------------------------
// dual_source_button_tracker
// Button table with two key slots per button and press/release edge latches.
// ----------------------------------------------------------------------------
// A command word is taken at every clock edge with start high; busy stays
// low, so one word per cycle is sustained. The response word shows on result
// with done high after the command passes vld_reg and then done_reg, for one cycle
// only; the receiver must take it then. Each in-range word does one read-modify-write
// of its button's table entry in the cycle after capture, so a following word
// on the same button sees the update. Reset clears the whole table at once.
// ----------------------------------------------------------------------------
module dual_source_button_tracker
    import btk_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t result
);

    localparam int DEPTH = (NUM_BUTTONS < (1 << BUTTON_IDX_W)) ? NUM_BUTTONS
                                                               : (1 << BUTTON_IDX_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t   cmd_reg;
    logic   vld_reg;
    rsp_t   rsp_reg;
    logic   done_reg;

    logic             in_range;
    logic [IDX_W-1:0] idx;
    entry_t           cur_entry;
    entry_t           nxt_entry;
    rsp_t             upd_rsp;
    rsp_t             rsp_next;

    assign busy     = 1'b0;
    assign in_range = {4'b0, cmd_reg.button_index} < 9'(NUM_BUTTONS);
    assign idx      = cmd_reg.button_index[IDX_W-1:0];
    assign rsp_next = in_range ? upd_rsp : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= start;
            done_reg <= vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
        if (vld_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    btk_table #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (vld_reg && in_range),
        .wr_idx  (idx),
        .wr_data (nxt_entry),
        .rd_idx  (idx),
        .rd_data (cur_entry)
    );

    btk_update u_update (
        .cmd (cmd_reg),
        .cur (cur_entry),
        .nxt (nxt_entry),
        .rsp (upd_rsp)
    );

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

@@ design/btk_checker.sv @@
// ----------------------------------------------------------------------------
// btk_checker
// Port-level timing and response checks for the button tracker.
// ----------------------------------------------------------------------------
module btk_checker
    import btk_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic done,
    input rsp_t result
);

    // every accepted word is answered with done
    a_word_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted word got no response");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("response without a word");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.held_fraction <= FRAC_FULL))
        else $error("held fraction above four quarters");

    a_fields_by_op: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (($past(cmd.op, 2) == OP_SAMPLE) || (result.held_fraction == FRAC_NONE))
              && (($past(cmd.op, 2) == OP_LATCH) || !result.action_active)
              && (($past(cmd.op, 2) == OP_PRESS) || !result.too_many_keys))
        else $error("response field set for wrong op");

endmodule

bind dual_source_button_tracker btk_checker u_btk_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);

@@ tb/dual_source_button_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// dual_source_button_tracker_tb
// Self-checking bench for the two-key button table. Directed words hit the
// slot and edge corner cases, then random press/release sessions and single
// random words, samples and latches mixed in. Every taken word is run through
// a local model of the table; each response word is checked against it in order.
// ----------------------------------------------------------------------------
module dual_source_button_tracker_tb;
    import btk_pkg::*;

    localparam int WORD_TARGET  = 1900;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 1000;

    typedef struct {
        cmd_t        word;
        int unsigned gap;
    } pending_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t result;

    pending_word_t pending[$];
    rsp_t          rsp_due[$];
    rsp_t          rsp_head;

    logic [SLOT_W-1:0] key_a      [NUM_BUTTONS_DEF] = '{default: SLOT_EMPTY};
    logic [SLOT_W-1:0] key_b      [NUM_BUTTONS_DEF] = '{default: SLOT_EMPTY};
    logic              held_now   [NUM_BUTTONS_DEF] = '{default: 1'b0};
    logic              press_edge [NUM_BUTTONS_DEF] = '{default: 1'b0};
    logic              rel_edge   [NUM_BUTTONS_DEF] = '{default: 1'b0};

    logic cmd_taken    = 1'b0;
    int   idle_left    = -1;
    int   stall_cycles = 0;
    int   errors       = 0;
    int   words_queued = 0;
    int   words_taken  = 0;
    bit   burst        = 1'b0;

    dual_source_button_tracker DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // table update for one word; returns the response it must produce
    function automatic rsp_t track_button(cmd_t w);
        rsp_t              r;
        int unsigned       b;
        logic [SLOT_W-1:0] k;
        bit                claimed;
        bit                freed;
        r       = '0;
        b       = 32'(w.button_index);
        k       = w.key_given ? {1'b0, w.key_code} : SLOT_MANUAL;
        claimed = 1'b0;
        freed   = 1'b0;
        case (w.op)
            OP_PRESS:
            begin
                if (k != key_a[b] && k != key_b[b])
                begin
                    if (key_a[b] == SLOT_EMPTY)
                    begin
                        key_a[b] = k;
                        claimed  = 1'b1;
                    end
                    else if (key_b[b] == SLOT_EMPTY)
                    begin
                        key_b[b] = k;
                        claimed  = 1'b1;
                    end
                    else
                        r.too_many_keys = 1'b1;
                    if (claimed && !held_now[b])
                    begin
                        held_now[b]   = 1'b1;
                        press_edge[b] = 1'b1;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (!w.key_given)
                begin
                    key_a[b]      = SLOT_EMPTY;
                    key_b[b]      = SLOT_EMPTY;
                    held_now[b]   = 1'b0;
                    press_edge[b] = 1'b0;
                    rel_edge[b]   = 1'b1;
                end
                else
                begin
                    if (key_a[b] == k)
                    begin
                        key_a[b] = SLOT_EMPTY;
                        freed    = 1'b1;
                    end
                    else if (key_b[b] == k)
                    begin
                        key_b[b] = SLOT_EMPTY;
                        freed    = 1'b1;
                    end
                    if (freed && key_a[b] == SLOT_EMPTY && key_b[b] == SLOT_EMPTY
                        && held_now[b])
                    begin
                        held_now[b] = 1'b0;
                        rel_edge[b] = 1'b1;
                    end
                end
            end
            OP_SAMPLE:
            begin
                case ({press_edge[b], rel_edge[b]})
                    2'b10:   r.held_fraction = held_now[b] ? FRAC_HALF : FRAC_NONE;
                    2'b01:   r.held_fraction = FRAC_NONE;
                    2'b00:   r.held_fraction = held_now[b] ? FRAC_FULL : FRAC_NONE;
                    default: r.held_fraction = held_now[b] ? FRAC_3QUART : FRAC_QUARTER;
                endcase
                press_edge[b] = 1'b0;
                rel_edge[b]   = 1'b0;
            end
            default:
            begin
                r.action_active = held_now[b] | press_edge[b];
                press_edge[b]   = 1'b0;
            end
        endcase
        r.is_held = held_now[b];
        return r;
    endfunction

    function automatic int unsigned draw_gap();
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic int unsigned pick_button();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
    endfunction

    function automatic int unsigned pick_key();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
    endfunction

    task automatic queue_word(op_t op, int unsigned idx, bit given, int unsigned code);
        pending_word_t p;
        p.word.op           = op;
        p.word.button_index = BUTTON_IDX_W'(idx);
        p.word.key_given    = given;
        p.word.key_code     = KEY_W'(code);
        p.gap               = draw_gap();
        pending.push_back(p);
        words_queued++;
    endtask

    task automatic sprinkle(int unsigned b);
        int unsigned n;
        n = $urandom_range(0, 2);
        repeat (n)
            queue_word($urandom_range(0, 1) ? OP_SAMPLE : OP_LATCH, b,
                       1'($urandom_range(0, 1)), $urandom_range(0, 255));
    endtask

    // one press/release session on a button, edges probed in between
    task automatic play_session();
        int unsigned b;
        int unsigned k1;
        int unsigned k2;
        b  = pick_button();
        k1 = pick_key();
        k2 = pick_key();
        queue_word(OP_PRESS, b, 1'b1, k1);
        sprinkle(b);
        if ($urandom_range(0, 2) != 0)
        begin
            queue_word(OP_PRESS, b, $urandom_range(0, 3) != 0, k2);
            sprinkle(b);
        end
        if ($urandom_range(0, 4) == 0)
            queue_word(OP_PRESS, b, 1'b1, pick_key());
        sprinkle(b);
        case ($urandom_range(0, 5))
            0:
                queue_word(OP_RELEASE, b, 1'b0, $urandom_range(0, 255));
            1:
            begin
                queue_word(OP_RELEASE, b, 1'b1, k2);
                sprinkle(b);
                queue_word(OP_RELEASE, b, 1'b1, k1);
            end
            2:
            begin
                queue_word(OP_RELEASE, b, 1'b1, pick_key());
                queue_word(OP_RELEASE, b, 1'b1, k1);
                sprinkle(b);
                queue_word(OP_RELEASE, b, 1'b1, k2);
            end
            default:
            begin
                queue_word(OP_RELEASE, b, 1'b1, k1);
                sprinkle(b);
                queue_word(OP_RELEASE, b, 1'b1, k2);
            end
        endcase
        sprinkle(b);
    endtask

    task automatic check_field(string name, logic [3:0] exp_val, logic [3:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || cmd_taken)
        begin
            if (pending.size() == 0)
                start <= 1'b0;
            else
            begin
                if (idle_left < 0)
                    idle_left = pending[0].gap;
                if (idle_left > 0)
                begin
                    idle_left = idle_left - 1;
                    start <= 1'b0;
                end
                else
                begin
                    cmd <= pending[0].word;
                    pending.delete(0);
                    start <= 1'b1;
                    idle_left = -1;
                end
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response word with nothing expected: %p", result);
                    errors++;
                end
                else
                begin
                    rsp_head = rsp_due.pop_front();
                    check_field("held_fraction", 4'(rsp_head.held_fraction),
                                4'(result.held_fraction));
                    check_field("is_held", 4'(rsp_head.is_held), 4'(result.is_held));
                    check_field("action_active", 4'(rsp_head.action_active),
                                4'(result.action_active));
                    check_field("too_many_keys", 4'(rsp_head.too_many_keys),
                                4'(result.too_many_keys));
                end
            end
            if (start && !busy)
            begin
                rsp_due.push_back(track_button(cmd));
                words_taken++;
            end
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
        cmd_taken <= rst_n && start && !busy;
    end

    initial
    begin
        // directed: slots, repeats, third key, edges and fractions
        queue_word(OP_PRESS,   0,  1'b1, 5);
        queue_word(OP_PRESS,   0,  1'b1, 5);
        queue_word(OP_PRESS,   0,  1'b1, 0);
        queue_word(OP_PRESS,   0,  1'b0, 8'h5A);
        queue_word(OP_PRESS,   0,  1'b1, 255);
        queue_word(OP_SAMPLE,  0,  1'b0, 0);
        queue_word(OP_LATCH,   0,  1'b1, 255);
        queue_word(OP_RELEASE, 0,  1'b1, 77);
        queue_word(OP_RELEASE, 0,  1'b1, 5);
        queue_word(OP_SAMPLE,  0,  1'b1, 0);
        queue_word(OP_RELEASE, 0,  1'b0, 8'hA5);
        queue_word(OP_SAMPLE,  0,  1'b0, 0);
        queue_word(OP_LATCH,   0,  1'b0, 0);
        queue_word(OP_PRESS,   31, 1'b1, 1);
        queue_word(OP_RELEASE, 31, 1'b1, 1);
        queue_word(OP_SAMPLE,  31, 1'b1, 255);
        queue_word(OP_PRESS,   31, 1'b1, 200);
        queue_word(OP_RELEASE, 31, 1'b1, 200);
        queue_word(OP_PRESS,   31, 1'b1, 128);
        queue_word(OP_SAMPLE,  31, 1'b0, 0);
        queue_word(OP_SAMPLE,  31, 1'b0, 0);
        queue_word(OP_LATCH,   31, 1'b0, 0);
        queue_word(OP_RELEASE, 31, 1'b1, 0);
        queue_word(OP_RELEASE, 31, 1'b0, 8'hFF);
        queue_word(OP_PRESS,   15, 1'b0, 8'hAA);

        while (words_queued < WORD_TARGET)
        begin
            if ($urandom_range(0, 15) == 0)
                burst = !burst;
            if ($urandom_range(0, 4) == 0)
                queue_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 31),
                           1'($urandom_range(0, 1)), $urandom_range(0, 255));
            else
                play_session();
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_taken < words_queued || rsp_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
